>>> src/swr_pkg.sv
`timescale 1ns / 1ps
package swr_pkg;

	localparam int MAX_WINDOW_DEF = 32;
	localparam int MAX_STREAM_DEF = 4096;
	localparam int TAIL_LIMIT     = 64;
	localparam int CFG_IDX_W      = 8;
	localparam int CFG_DATA_W     = 13;

	typedef enum logic [1:0] {
		OP_SUM = 2'd0,
		OP_MIN = 2'd1,
		OP_MAX = 2'd2,
		OP_RSV = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OP     = 8'd0,
		REG_PAD    = 8'd1,
		REG_SIGNED = 8'd2,
		REG_WIDE   = 8'd3,
		REG_LEN    = 8'd4,
		REG_STEP   = 8'd5,
		REG_LPAD   = 8'd6,
		REG_COUNT  = 8'd7
	} reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_TEST,
		S_MOD,
		S_ACC,
		S_OUT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic sgn;
		logic wide;
	} lane_cfg_t;

	function automatic logic [63:0] lane_mask(input logic wide);
		return wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
	endfunction

	function automatic logic [63:0] sign_bit(input logic wide);
		return wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
	endfunction

	function automatic logic [63:0] order_key(input lane_cfg_t c, input logic [63:0] v);
		return c.sgn ? (v ^ sign_bit(c.wide)) : v;
	endfunction

	function automatic logic [63:0] identity(input lane_cfg_t c);
		logic [63:0] r;
		r = '0;
		case (c.op)
			OP_MIN:  r = c.sgn ? (lane_mask(c.wide) ^ sign_bit(c.wide)) : lane_mask(c.wide);
			OP_MAX:  r = c.sgn ? sign_bit(c.wide) : 64'd0;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] reduce2(input lane_cfg_t c, input logic [63:0] a,
			input logic [63:0] b);
		logic [63:0] r;
		r = a;
		case (c.op)
			OP_MIN:  r = (order_key(c, b) < order_key(c, a)) ? b : a;
			OP_MAX:  r = (order_key(c, b) > order_key(c, a)) ? b : a;
			default: r = (a + b) & lane_mask(c.wide);
		endcase
		return r;
	endfunction

endpackage

>>> src/swr_cell.sv
`timescale 1ns / 1ps
module swr_cell
	import swr_pkg::*;
(
	input  logic        clk,
	input  logic        shift,
	input  logic [63:0] d,
	output logic [63:0] q
);

	logic [63:0] val_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

>>> src/swr_modu.sv
`timescale 1ns / 1ps
module swr_modu
	import swr_pkg::*;
#(
	parameter int DIVISOR = MAX_WINDOW_DEF,
	parameter int POS_W   = 19
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  logic [POS_W-1:0]             dividend,
	output logic                         done,
	output logic [$clog2(DIVISOR)-1:0]   rem
);

	localparam int IdxW = $clog2(DIVISOR);
	localparam int ShW  = POS_W + IdxW;
	localparam int MulW = ShW + 1;
	localparam int ProdW = POS_W + MulW;
	localparam logic [MulW-1:0] RECIP =
		MulW'(((64'd1 << ShW) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

	logic             vld_s1;
	logic [POS_W-1:0] div_s1;
	logic [ProdW-1:0] prod_s1;
	logic [POS_W-1:0] quo;
	logic [POS_W-1:0] rem_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			div_s1  <= dividend;
			prod_s1 <= ProdW'(dividend) * ProdW'(RECIP);
		end
	end

	always_comb begin
		quo      = prod_s1[ShW +: POS_W];
		rem_full = div_s1 - quo * POS_W'(DIVISOR);
	end

	assign done = vld_s1;
	assign rem  = rem_full[IdxW-1:0];

endmodule

>>> src/sliding_window_reduce.sv
`timescale 1ns / 1ps
// Sliding window sum / min / max over a sample stream with left padding.
// Input channel: sample and end_of_stream move on in_valid high, in_stall low.
// Output channel: reduced, window_index, final_result, tail_truncated move on
// out_valid high, out_stall low. Config: cfg_index / cfg_data written on
// cfg_valid with cfg_ready, which is always high; write only while idle.
// Samples shift into a row of MAX_WINDOW cells, newest at the head.
// Each sample passes the start multiply and the window test. Each result
// passes them too, then the ring offset remainder by reciprocal multiply
// (skipped on tail-only windows), a pass over every window position through
// the shared reducer, and the output state; the result holds there for as
// long as out_stall stays high, and no sample is taken meanwhile. At
// end_of_stream up to 64 results follow that sample.
// Reset returns the configuration to its defaults and starts a new stream;
// the cells themselves are not cleared and are never read before written.
module sliding_window_reduce
	import swr_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int MAX_STREAM = MAX_STREAM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [63:0]           sample,
	input  logic                  end_of_stream,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [63:0]           reduced,
	output logic [11:0]           window_index,
	output logic                  final_result,
	output logic                  tail_truncated,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IdxW = $clog2(MAX_WINDOW);
	localparam int CntW = $clog2(MAX_STREAM + 1);
	localparam int PosW = $clog2(MAX_STREAM * 64 + 128) + 1;

	op_t         op_q;
	logic        pmode_q;
	logic        sgn_q;
	logic        wide_q;
	logic [5:0]  len_q;
	logic [5:0]  step_q;
	logic [5:0]  lpad_q;
	logic [12:0] count_q;

	state_t      state_q;
	state_t      state_nxt;
	logic        eos_q;
	logic [PosW-1:0] have_q;
	logic [CntW-1:0] nw_q;
	logic [6:0]  n_q;
	logic [PosW-1:0] start_s1;
	logic [PosW-1:0] p_q;
	logic [5:0]  k_q;
	logic [IdxW-1:0] idx_q;
	logic [63:0] acc_q;
	logic [63:0] first_q;

	lane_cfg_t   lcfg;
	logic [5:0]  eff_len;
	logic [5:0]  eff_step;
	logic [5:0]  eff_pad;
	logic [CntW-1:0] eff_cnt;
	logic        in_xfer;
	logic        out_xfer;
	logic        store;
	logic [63:0] s_masked;
	logic        emit_ok;
	logic        d_neg;
	logic [PosW-1:0] d_val;
	logic        mod_go;
	logic        mod_done;
	logic [IdxW-1:0] mod_rem;
	logic        last_k;
	logic [63:0] v_cur;
	logic [63:0] taps [MAX_WINDOW];
	logic        is_last_nw;

	assign lcfg     = '{op: op_q, sgn: sgn_q, wide: wide_q};
	assign eff_len  = (len_q == 6'd0) ? 6'd1 :
		((32'(len_q) > 32'(MAX_WINDOW)) ? 6'(MAX_WINDOW) : len_q);
	assign eff_step = (step_q == 6'd0) ? 6'd1 : step_q;
	assign eff_pad  = (lpad_q > eff_len) ? eff_len : lpad_q;
	assign eff_cnt  = (count_q == 13'd0) ? CntW'(1) :
		((32'(count_q) > 32'(MAX_STREAM)) ? CntW'(MAX_STREAM) : CntW'(count_q));

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign store    = in_xfer && (nw_q < eff_cnt);
	assign s_masked = sample & lane_mask(wide_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_SUM;
			pmode_q <= 1'b0;
			sgn_q   <= 1'b1;
			wide_q  <= 1'b1;
			len_q   <= 6'd3;
			step_q  <= 6'd1;
			lpad_q  <= 6'd1;
			count_q <= 13'd4096;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_OP:     op_q    <= op_t'(cfg_data[1:0]);
				REG_PAD:    pmode_q <= cfg_data[0];
				REG_SIGNED: sgn_q   <= cfg_data[0];
				REG_WIDE:   wide_q  <= cfg_data[0];
				REG_LEN:    len_q   <= cfg_data[5:0];
				REG_STEP:   step_q  <= cfg_data[5:0];
				REG_LPAD:   lpad_q  <= cfg_data[5:0];
				REG_COUNT:  count_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	for (genvar c = 0; c < MAX_WINDOW; c++) begin : g_cell
		if (c == 0) begin : g_head
			swr_cell u_cell (.clk(clk), .shift(store), .d(s_masked), .q(taps[c]));
		end else begin : g_body
			swr_cell u_cell (.clk(clk), .shift(store), .d(taps[c-1]), .q(taps[c]));
		end
	end

	swr_modu #(
		.DIVISOR(MAX_WINDOW),
		.POS_W  (PosW)
	) u_modu (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (mod_go),
		.dividend(d_val),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	assign emit_ok = (nw_q < eff_cnt) && (n_q < 7'(TAIL_LIMIT)) &&
		(eos_q || ((PosW+1)'(start_s1) + (PosW+1)'(eff_len) <=
		(PosW+1)'(eff_pad) + (PosW+1)'(have_q)));
	assign d_neg   = ((PosW+1)'(have_q) + (PosW+1)'(eff_pad)) < ((PosW+1)'(start_s1) + 1'b1);
	assign d_val   = have_q + PosW'(eff_pad) - PosW'(1) - start_s1;
	assign mod_go  = (state_q == S_TEST) && emit_ok && !d_neg;
	assign last_k  = (k_q == eff_len - 6'd1);

	always_comb begin
		if (p_q < PosW'(eff_pad)) begin
			v_cur = pmode_q ? first_q : identity(lcfg);
		end else if (p_q - PosW'(eff_pad) < have_q) begin
			v_cur = taps[idx_q];
		end else begin
			v_cur = pmode_q ? taps[0] : identity(lcfg);
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (in_xfer) state_nxt = S_MUL;
			S_MUL:  state_nxt = S_TEST;
			S_TEST: begin
				if (!emit_ok) state_nxt = S_IDLE;
				else if (d_neg) state_nxt = S_ACC;
				else state_nxt = S_MOD;
			end
			S_MOD:  if (mod_done) state_nxt = S_ACC;
			S_ACC:  if (last_k) state_nxt = S_OUT;
			S_OUT:  if (out_xfer) state_nxt = S_MUL;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			eos_q   <= 1'b0;
			have_q  <= '0;
			nw_q    <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_xfer) begin
				eos_q <= end_of_stream;
				n_q   <= '0;
			end
			if (store) begin
				have_q <= have_q + 1'b1;
			end
			if (out_xfer) begin
				nw_q <= nw_q + 1'b1;
				n_q  <= n_q + 1'b1;
			end
			if (state_q == S_TEST && !emit_ok && eos_q) begin
				have_q <= '0;
				nw_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store && have_q == '0) begin
			first_q <= s_masked;
		end
		if (state_q == S_MUL) begin
			start_s1 <= PosW'(nw_q) * PosW'(eff_step);
		end
		if (state_q == S_TEST) begin
			p_q   <= start_s1;
			k_q   <= '0;
			idx_q <= '0;
		end
		if (state_q == S_MOD && mod_done) begin
			idx_q <= mod_rem;
		end
		if (state_q == S_ACC) begin
			acc_q <= (k_q == 6'd0) ? v_cur : reduce2(lcfg, acc_q, v_cur);
			k_q   <= k_q + 6'd1;
			p_q   <= p_q + 1'b1;
			idx_q <= (idx_q == '0) ? IdxW'(MAX_WINDOW - 1) : idx_q - 1'b1;
		end
	end

	assign is_last_nw = (nw_q + 1'b1 == eff_cnt);

	always_comb begin
		in_stall       = (state_q != S_IDLE);
		out_valid      = (state_q == S_OUT);
		reduced        = acc_q;
		window_index   = 12'(nw_q);
		final_result   = is_last_nw || (eos_q && n_q == 7'(TAIL_LIMIT - 1));
		tail_truncated = eos_q && (n_q == 7'(TAIL_LIMIT - 1)) && !is_last_nw;
	end

	assign cfg_ready = 1'b1;

`ifndef SYNTHESIS
	a_trunc_final: assert property (@(posedge clk) disable iff (!arst_n)
		tail_truncated |-> final_result)
		else $error("truncation flag without final result");
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("sample taken while a result is pending");
	a_final_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && tail_truncated) |=> !out_valid)
		else $error("result after truncated tail");
`endif

endmodule
